@@ hw/rtl/mbds_pkg.sv @@
// Shared types, constants and helpers of the multibyte delimiter splitter.
package mbds_pkg;

  localparam int MAX_SEP_DEF  = 8;
  localparam int Q_DEPTH_DEF  = 2;
  localparam int SEP_LEN_W    = 4;
  localparam int SEP_BYTES_W  = 64;
  localparam int SEP_BYTES_N  = SEP_BYTES_W / 8;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES = 1'd1;

  localparam logic [SEP_LEN_W-1:0]   SEP_LEN_RST   = 4'd1;
  localparam logic [SEP_BYTES_W-1:0] SEP_BYTES_RST = 64'd44;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       string_done;
    logic       run_last;
  } out_item_t;

  typedef struct packed {
    logic [SEP_LEN_W-1:0]   sep_len;
    logic [SEP_BYTES_W-1:0] sep_bytes;
  } cfg_t;

  // Delimiter byte k; positions past the register read as zero.
  function automatic logic [7:0] delim_byte(input logic [SEP_BYTES_W-1:0] b, input int k);
    logic [7:0] r;
    r = '0;
    for (int j = 0; j < SEP_BYTES_N; j++) begin
      if (j == k) r = b[8*j +: 8];
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/mbds_queue.sv @@
// Small synchronous queue used on both sides of the splitter engine.
module mbds_queue #(
  parameter type T     = logic [7:0],
  parameter int  DEPTH = mbds_pkg::Q_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     din,
  output logic full,
  input  logic pop,
  output T     dout,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ hw/rtl/mbds_engine.sv @@
// Splitter engine: window of held bytes, delimiter match and end-of-string flush.
module mbds_engine #(
  parameter int MAX_SEP = mbds_pkg::MAX_SEP_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mbds_pkg::cfg_t      cfg,
  input  logic                item_valid,
  input  mbds_pkg::in_item_t  item,
  output logic                take,
  input  logic                res_full,
  output logic                res_push,
  output mbds_pkg::out_item_t res
);

  localparam int CW = $clog2(MAX_SEP + 1);

  logic [7:0]    win_r [MAX_SEP];
  logic [7:0]    win_nxt [MAX_SEP];
  logic [7:0]    w [MAX_SEP];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          has_r, has_nxt;
  logic          busy_r, busy_nxt;
  logic          last_r, last_nxt;

  logic [mbds_pkg::SEP_LEN_W:0] sl_ext;
  logic [CW-1:0] len;
  logic [CW-1:0] n;
  logic [CW-1:0] shamt;
  logic          lst, act, match, emit, is_end, more, advance;

  // Effective delimiter length: zero acts as one, clamp to the window size.
  always_comb begin
    sl_ext = {1'b0, cfg.sep_len};
    if (sl_ext == '0) begin
      len = CW'(1);
    end else if (sl_ext > (mbds_pkg::SEP_LEN_W + 1)'(MAX_SEP)) begin
      len = CW'(MAX_SEP);
    end else begin
      len = CW'(sl_ext);
    end
  end

  // Working window: held bytes plus the new byte when an item enters.
  always_comb begin
    act = busy_r || item_valid;
    lst = busy_r ? last_r : item.in_last;
    n   = busy_r ? cnt_r : cnt_r + CW'(1);
    for (int i = 0; i < MAX_SEP; i++) begin
      w[i] = (!busy_r && (cnt_r == CW'(i))) ? item.in_byte : win_r[i];
    end
    match = 1'b1;
    for (int k = 0; k < MAX_SEP; k++) begin
      if ((CW'(k) < len) && (w[k] != mbds_pkg::delim_byte(cfg.sep_bytes, k))) begin
        match = 1'b0;
      end
    end
  end

  // One action per cycle while the result queue has room: match, shift out, flush, or close the field.
  always_comb begin
    emit    = 1'b0;
    is_end  = 1'b0;
    shamt   = '0;
    cnt_nxt = n;
    has_nxt = has_r;
    priority if (!act) begin
      cnt_nxt = cnt_r;
    end else if (n >= len) begin
      emit = 1'b1;
      if (match) begin
        is_end  = 1'b1;
        shamt   = len;
        cnt_nxt = n - len;
        has_nxt = 1'b0;
      end else begin
        shamt   = CW'(1);
        cnt_nxt = n - CW'(1);
        has_nxt = 1'b1;
      end
    end else if (lst && (n != '0)) begin
      emit    = 1'b1;
      shamt   = CW'(1);
      cnt_nxt = n - CW'(1);
      has_nxt = 1'b1;
    end else if (lst && has_r) begin
      emit    = 1'b1;
      is_end  = 1'b1;
      cnt_nxt = '0;
      has_nxt = 1'b0;
    end else begin
      emit = 1'b0;
    end

    more     = act && ((cnt_nxt >= len) || (lst && ((cnt_nxt != '0) || has_nxt)));
    busy_nxt = more;
    last_nxt = lst;
    advance  = act && !(emit && res_full);

    for (int i = 0; i < MAX_SEP; i++) begin
      win_nxt[i] = w[i];
      for (int j = i + 1; j < MAX_SEP; j++) begin
        if (shamt == CW'(j - i)) win_nxt[i] = w[j];
      end
    end
  end

  assign take     = !busy_r && item_valid && advance;
  assign res_push = emit && advance;

  always_comb begin
    res.kind        = is_end ? mbds_pkg::KIND_END : mbds_pkg::KIND_DATA;
    res.out_byte    = is_end ? 8'd0 : w[0];
    res.string_done = lst && !more;
    res.run_last    = !more;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      has_r  <= 1'b0;
      busy_r <= 1'b0;
      last_r <= 1'b0;
    end else if (advance) begin
      cnt_r  <= cnt_nxt;
      has_r  <= has_nxt;
      busy_r <= busy_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      win_r <= win_nxt;
    end
  end

endmodule

@@ hw/rtl/multibyte_delimiter_splitter.sv @@
// Multibyte delimiter splitter top: input queue, splitter engine and result queue.
// A byte is registered in the front queue and its result in the result queue; the engine between is combinational.
// Throughput: one byte per cycle while the engine is free and the result queue has room; a byte holds the engine
// until every result it causes is emitted, so a string's last byte also waits for the flush and the field end.
// Reset (rst_n low, synchronous): empties both queues and the window, sets sep_len to 1
// and the delimiter to a comma.
module multibyte_delimiter_splitter #(
  parameter int MAX_SEP = mbds_pkg::MAX_SEP_DEF,
  parameter int Q_DEPTH = mbds_pkg::Q_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              push,
  input  mbds_pkg::in_item_t                in_data,
  output logic                              full,
  // result channel
  output logic                              empty,
  input  logic                              pop,
  output mbds_pkg::out_item_t               out_data,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [mbds_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [mbds_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers; the user must write them only while the block is idle, the block does not enforce it.
  logic [mbds_pkg::SEP_LEN_W-1:0]   sep_len_r;
  logic [mbds_pkg::SEP_BYTES_W-1:0] sep_bytes_r;
  mbds_pkg::cfg_t                   cfg;

  // Front queue to engine
  logic               in_q_empty;
  logic               in_take;
  mbds_pkg::in_item_t in_head;

  // Engine to result queue
  logic                res_q_full;
  logic                res_push;
  mbds_pkg::out_item_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_len_r   <= mbds_pkg::SEP_LEN_RST;
      sep_bytes_r <= mbds_pkg::SEP_BYTES_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        mbds_pkg::CFG_SEP_LEN: begin
          sep_len_r <= cfg_wdata[mbds_pkg::SEP_LEN_W-1:0];
        end
        mbds_pkg::CFG_SEP_BYTES: begin
          sep_bytes_r <= cfg_wdata[mbds_pkg::SEP_BYTES_W-1:0];
        end
        default: begin
          sep_len_r <= sep_len_r;
        end
      endcase
    end
  end

  assign cfg.sep_len   = sep_len_r;
  assign cfg.sep_bytes = sep_bytes_r;

  // Front: hold incoming bytes so the producer can keep pushing while the engine flushes,
  // until the front queue is full.
  mbds_queue #(
    .T     (mbds_pkg::in_item_t),
    .DEPTH (Q_DEPTH)
  ) u_in_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (in_data),
    .full  (full),
    .pop   (in_take),
    .dout  (in_head),
    .empty (in_q_empty)
  );

  // Back: match against the delimiter and emit at most one result per cycle while the result queue has room.
  mbds_engine #(
    .MAX_SEP (MAX_SEP)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .item_valid (!in_q_empty),
    .item       (in_head),
    .take       (in_take),
    .res_full   (res_q_full),
    .res_push   (res_push),
    .res        (res)
  );

  // Result queue parts the engine from the consumer's pop.
  mbds_queue #(
    .T     (mbds_pkg::out_item_t),
    .DEPTH (Q_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_q_full),
    .pop   (pop),
    .dout  (out_data),
    .empty (empty)
  );

`ifndef SYNTH
  // The engine takes a byte only when the front queue has one.
  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |-> !in_q_empty)
    else $error("engine took a byte from an empty front queue");

  // The engine never pushes into a full result queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_q_full)
    else $error("result pushed into a full result queue");

  // The string's final result also closes its input byte.
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && res.string_done) |-> res.run_last)
    else $error("string_done without run_last");

  // A length write lands in the register on the next edge.
  a_len_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && (cfg_idx == mbds_pkg::CFG_SEP_LEN)) |=>
      (sep_len_r == $past(cfg_wdata[mbds_pkg::SEP_LEN_W-1:0])))
    else $error("sep_len write lost");
`endif

endmodule
